FILE: rtl/linked_list_manager_assert.svh
// Assertion macros shared by the linked list manager RTL.
`ifndef LINKED_LIST_MANAGER_ASSERT_SVH
`define LINKED_LIST_MANAGER_ASSERT_SVH
// Concurrent assertion on the block clock, quiet during reset.
`define LLM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Same, but also checked while reset is high.
`define LLM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

FILE: rtl/llm_pkg.sv
// Package with commands, status codes and shared constants of the linked list manager.
package llm_pkg;
   localparam int unsigned CAPACITY_DEFAULT = 32;
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned STAT_W  = 3;

   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE_POS = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE_VAL = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
endpackage

FILE: rtl/llm_node_ram.sv
// Node store: value and link per node, one write port, one registered read port.
module llm_node_ram #(
   parameter int unsigned CAPACITY = llm_pkg::CAPACITY_DEFAULT,
   parameter int unsigned AW = $clog2(CAPACITY + 1)
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic                               wr_val_en,
   input  logic [llm_pkg::VALUE_W-1:0]        wr_value,
   input  logic                               wr_link_en,
   input  logic [AW-1:0]                      wr_link,
   input  logic [AW-1:0]                      rd_addr,
   output logic [llm_pkg::VALUE_W-1:0]        rd_value_ff,
   output logic [AW-1:0]                      rd_link_ff
);
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [llm_pkg::VALUE_W-1:0] value_mem [CAPACITY];
   logic [AW-1:0]               link_mem  [CAPACITY];

   // writes only land below CAPACITY; a read at the null pointer returns data nobody uses
   always_ff @(posedge clock) begin
      if (wr_en && wr_val_en) begin
         value_mem[wr_addr[IW-1:0]] <= wr_value;
      end
      if (wr_en && wr_link_en) begin
         link_mem[wr_addr[IW-1:0]] <= wr_link;
      end
      rd_value_ff <= value_mem[rd_addr[IW-1:0]];
      rd_link_ff  <= link_mem[rd_addr[IW-1:0]];
   end
endmodule

FILE: rtl/linked_list_manager.sv
// Linked list manager top level: command sequencer around the node store.
// Keeps an ordered list of signed 32-bit values in a store of CAPACITY nodes, each with a value
// and a next link held in one synchronous memory (one read and one write per cycle, read data
// registered). Every request gives exactly one response on the rsp_ channel. One request is
// in work at a time and req_stall is high from its acceptance until its response is taken, so a
// new request is accepted at the earliest in the cycle after the response handshake. Each node
// walked passes through S_ISSUE, which presents its address, and S_WAIT, which uses its value
// and link; an insert that pops a node off the free list first reads the free head the same
// way, and a request that must patch two links (insert after the first position, delete of a
// node that is not the head) also passes through S_FIX. Clear, rejected requests and unused
// codes walk no nodes; the longest requests are a delete at the end of a full list and an
// insert at the end of a list one short of full that pops a free node. Memory writes are
// registered in the wr_ registers before they land in the store; the sequencer never reads an
// entry whose write is still pending, so no forwarding is needed. No clearing pass is needed
// after reset: nodes are handed out from a fresh counter and a free list, so an entry is always
// written before it is read.
module linked_list_manager #(
   parameter int unsigned CAPACITY = llm_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [llm_pkg::CMD_W-1:0]         req_cmd,
   input  logic [llm_pkg::POS_W-1:0]         req_position,
   input  logic signed [llm_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [llm_pkg::STAT_W-1:0]        rsp_status,
   output logic [llm_pkg::POS_W-1:0]         rsp_found_position,
   output logic [llm_pkg::POS_W-1:0]         rsp_node_count
);
`include "linked_list_manager_assert.svh"

   // pointers and counts share one width: enough to hold CAPACITY (null)
   localparam int unsigned AW = $clog2(CAPACITY + 1);
   // compare width for positions against counts
   localparam int unsigned CW = ((AW > llm_pkg::POS_W) ? AW : llm_pkg::POS_W) + 1;
   localparam logic [AW-1:0] NIL = AW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_ISSUE, S_WAIT, S_FIX, S_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic [llm_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [llm_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [llm_pkg::VALUE_W-1:0]     val_ff, val_in;
   logic [AW-1:0]                   head_ff, head_in, free_ff, free_in;
   logic [AW-1:0]                   fresh_ff, fresh_in, count_ff, count_in;
   logic [AW-1:0]                   cur_ff, cur_in, prev_ff, prev_in;
   logic [AW-1:0]                   newn_ff, newn_in; // node being linked in or freed
   logic [AW-1:0]                   k_ff, k_in;       // 1-based position of cur
   logic                            pop_ff, pop_in;   // read is of the free-list head
   logic [llm_pkg::STAT_W-1:0]      status_ff, status_in;
   logic [llm_pkg::POS_W-1:0]       found_ff, found_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            wr_en_ff, wr_en_in, wr_val_en_ff, wr_val_en_in;
   logic [AW-1:0]                   wr_addr_ff, wr_addr_in, wr_link_ff, wr_link_in;

   logic [llm_pkg::VALUE_W-1:0]     rd_value;
   logic [AW-1:0]                   rd_link;

   llm_node_ram #(.CAPACITY(CAPACITY), .AW(AW)) u_ram (
      .clock      (clock),
      .wr_en      (wr_en_ff),
      .wr_addr    (wr_addr_ff),
      .wr_val_en  (wr_val_en_ff),
      .wr_value   (val_ff),
      .wr_link_en (1'b1),
      .wr_link    (wr_link_ff),
      .rd_addr    (cur_ff),
      .rd_value_ff(rd_value),
      .rd_link_ff (rd_link)
   );

   wire req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_node_count = llm_pkg::POS_W'(count_ff);

   wire [CW-1:0] pos_x  = CW'(pos_ff);
   wire [CW-1:0] cnt_x  = CW'(count_ff);
   wire [CW-1:0] k_x    = CW'(k_ff);
   wire          match  = (rd_value == val_ff);
   wire          at_end = (k_x == cnt_x); // node read is the last one of the list

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; pos_in = pos_ff; val_in = val_ff;
      head_in = head_ff; free_in = free_ff; fresh_in = fresh_ff; count_in = count_ff;
      cur_in = cur_ff; prev_in = prev_ff; newn_in = newn_ff; k_in = k_ff; pop_in = pop_ff;
      status_in = status_ff; found_in = found_ff;
      wr_en_in = 1'b0; wr_val_en_in = 1'b0; wr_addr_in = wr_addr_ff; wr_link_in = wr_link_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in = req_cmd;
               pos_in = req_position;
               val_in = req_value;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = llm_pkg::ST_OK;
            found_in = '0;
            state_in = S_RESP;
            cur_in = head_ff; prev_in = NIL; k_in = AW'(1); pop_in = 1'b0;
            case (cmd_ff)
               llm_pkg::CMD_INSERT: begin
                  if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                     status_in = llm_pkg::ST_BAD_POS;
                  end else if (count_ff >= NIL) begin
                     status_in = llm_pkg::ST_FULL;
                  end else if (free_ff != NIL) begin
                     // read the free head's link first to pop it
                     newn_in = free_ff; cur_in = free_ff; pop_in = 1'b1;
                     state_in = S_ISSUE;
                  end else if (fresh_ff >= NIL) begin
                     status_in = llm_pkg::ST_FULL;
                  end else begin
                     newn_in = fresh_ff;
                     fresh_in = fresh_ff + 1'b1;
                     if (pos_x == CW'(1)) begin
                        wr_en_in = 1'b1; wr_val_en_in = 1'b1;
                        wr_addr_in = fresh_ff; wr_link_in = head_ff;
                        head_in = fresh_ff;
                        count_in = count_ff + 1'b1;
                     end else begin
                        state_in = S_ISSUE;
                     end
                  end
               end
               llm_pkg::CMD_DELETE_POS: begin
                  if (count_ff == '0) begin
                     status_in = llm_pkg::ST_EMPTY;
                  end else if (pos_x == '0 || pos_x > cnt_x) begin
                     status_in = llm_pkg::ST_BAD_POS;
                  end else begin
                     state_in = S_ISSUE;
                  end
               end
               llm_pkg::CMD_DELETE_VAL, llm_pkg::CMD_SEARCH,
               llm_pkg::CMD_REVERSE: begin
                  if (count_ff == '0) begin
                     status_in = llm_pkg::ST_EMPTY;
                  end else begin
                     state_in = S_ISSUE;
                  end
               end
               llm_pkg::CMD_CLEAR: begin
                  head_in = NIL; free_in = NIL; fresh_in = '0; count_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_ISSUE: begin
            // memory samples cur this edge; data is usable next cycle
            state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_ISSUE;
            if (pop_ff) begin
               pop_in = 1'b0;
               free_in = rd_link;
               if (pos_x == CW'(1)) begin
                  wr_en_in = 1'b1; wr_val_en_in = 1'b1;
                  wr_addr_in = newn_ff; wr_link_in = head_ff;
                  head_in = newn_ff;
                  count_in = count_ff + 1'b1;
                  state_in = S_RESP;
               end else begin
                  cur_in = head_ff; k_in = AW'(1);
               end
            end else begin
               case (cmd_ff)
                  llm_pkg::CMD_INSERT: begin
                     if (k_x == pos_x - 1'b1) begin
                        // new node takes the successor; predecessor is patched next
                        wr_en_in = 1'b1; wr_val_en_in = 1'b1;
                        wr_addr_in = newn_ff; wr_link_in = rd_link;
                        prev_in = cur_ff;
                        state_in = S_FIX;
                     end else begin
                        cur_in = rd_link; k_in = k_ff + 1'b1;
                     end
                  end
                  llm_pkg::CMD_DELETE_POS, llm_pkg::CMD_DELETE_VAL: begin
                     if ((cmd_ff == llm_pkg::CMD_DELETE_POS && k_x == pos_x) ||
                         (cmd_ff == llm_pkg::CMD_DELETE_VAL && match)) begin
                        // cur is the victim: unlink it, then push it on the free list
                        newn_in = cur_ff;
                        if (prev_ff == NIL) begin
                           head_in = rd_link;
                           wr_en_in = 1'b1; wr_addr_in = cur_ff; wr_link_in = free_ff;
                           free_in = cur_ff;
                           count_in = count_ff - 1'b1;
                           state_in = S_RESP;
                        end else begin
                           wr_en_in = 1'b1; wr_addr_in = prev_ff; wr_link_in = rd_link;
                           state_in = S_FIX;
                        end
                     end else if (at_end) begin
                        status_in = llm_pkg::ST_NOT_FOUND;
                        state_in = S_RESP;
                     end else begin
                        prev_in = cur_ff; cur_in = rd_link; k_in = k_ff + 1'b1;
                     end
                  end
                  llm_pkg::CMD_SEARCH: begin
                     if (match) begin
                        found_in = llm_pkg::POS_W'(k_ff);
                        state_in = S_RESP;
                     end else if (at_end) begin
                        status_in = llm_pkg::ST_NOT_FOUND;
                        state_in = S_RESP;
                     end else begin
                        cur_in = rd_link; k_in = k_ff + 1'b1;
                     end
                  end
                  llm_pkg::CMD_REVERSE: begin
                     // point the node back at its predecessor
                     wr_en_in = 1'b1; wr_addr_in = cur_ff; wr_link_in = prev_ff;
                     prev_in = cur_ff; cur_in = rd_link;
                     if (at_end) begin
                        head_in = cur_ff;
                        state_in = S_RESP;
                     end else begin
                        k_in = k_ff + 1'b1;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_FIX: begin
            state_in = S_RESP;
            if (cmd_ff == llm_pkg::CMD_INSERT) begin
               wr_en_in = 1'b1; wr_addr_in = prev_ff; wr_link_in = newn_ff;
               count_in = count_ff + 1'b1;
            end else begin
               wr_en_in = 1'b1; wr_addr_in = newn_ff; wr_link_in = free_ff;
               free_in = newn_ff;
               count_in = count_ff - 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // response is valid exactly while the sequencer waits in S_RESP
      rsp_valid_in = (state_in == S_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmd_ff <= '0; pos_ff <= '0; val_ff <= '0;
         head_ff <= NIL; free_ff <= NIL; fresh_ff <= '0; count_ff <= '0;
         cur_ff <= NIL; prev_ff <= NIL; newn_ff <= NIL; k_ff <= '0; pop_ff <= 1'b0;
         status_ff <= llm_pkg::ST_OK; found_ff <= '0; rsp_valid_ff <= 1'b0;
         wr_en_ff <= 1'b0; wr_val_en_ff <= 1'b0; wr_addr_ff <= '0; wr_link_ff <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff <= cmd_in; pos_ff <= pos_in; val_ff <= val_in;
         head_ff <= head_in; free_ff <= free_in; fresh_ff <= fresh_in; count_ff <= count_in;
         cur_ff <= cur_in; prev_ff <= prev_in; newn_ff <= newn_in; k_ff <= k_in;
         pop_ff <= pop_in;
         status_ff <= status_in; found_ff <= found_in; rsp_valid_ff <= rsp_valid_in;
         wr_en_ff <= wr_en_in; wr_val_en_ff <= wr_val_en_in;
         wr_addr_ff <= wr_addr_in; wr_link_ff <= wr_link_in;
      end
   end

   `LLM_ASSERT(a_rsp_only_resp, rsp_valid_ff |-> state_ff == S_RESP, "response valid outside response state")
   `LLM_ASSERT(a_count_bound, count_ff <= NIL, "node count above capacity")
   `LLM_ASSERT(a_fresh_bound, fresh_ff <= NIL, "fresh node counter above capacity")
   `LLM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found_position) && $stable(rsp_node_count), "stalled response changed")
endmodule

FILE: tb/linked_list_manager_tb.sv
// Testbench for the linked list manager: random and directed list commands, scoreboard check.
`timescale 1ns / 100ps

class list_scoreboard;
   localparam int CAP = llm_pkg::CAPACITY_DEFAULT;
   logic [31:0] val_q[$];
   logic [2:0]  exp_status[$];
   logic [5:0]  exp_found[$];
   logic [5:0]  exp_count[$];
   int errors;

   // Apply one accepted request to the shadow list and queue its response.
   function void note_request(logic [2:0] cmd, logic [5:0] pos, logic [31:0] value);
      logic [2:0] st;
      logic [5:0] fnd;
      int idx;
      st = llm_pkg::ST_OK;
      fnd = '0;
      idx = -1;
      case (cmd)
         llm_pkg::CMD_INSERT: begin
            if (pos < 1 || pos > val_q.size() + 1) st = llm_pkg::ST_BAD_POS;
            else if (val_q.size() >= CAP) st = llm_pkg::ST_FULL;
            else val_q.insert(int'(pos) - 1, value);
         end
         llm_pkg::CMD_DELETE_POS: begin
            if (val_q.size() == 0) st = llm_pkg::ST_EMPTY;
            else if (pos < 1 || pos > val_q.size()) st = llm_pkg::ST_BAD_POS;
            else val_q.delete(int'(pos) - 1);
         end
         llm_pkg::CMD_DELETE_VAL, llm_pkg::CMD_SEARCH: begin
            if (val_q.size() == 0) st = llm_pkg::ST_EMPTY;
            else begin
               for (int k = 0; k < val_q.size(); k++)
                  if (idx < 0 && val_q[k] == value) idx = k;
               if (idx < 0) st = llm_pkg::ST_NOT_FOUND;
               else if (cmd == llm_pkg::CMD_SEARCH) fnd = 6'(idx + 1);
               else val_q.delete(idx);
            end
         end
         llm_pkg::CMD_REVERSE: begin
            if (val_q.size() == 0) st = llm_pkg::ST_EMPTY;
            else val_q.reverse();
         end
         llm_pkg::CMD_CLEAR: val_q.delete();
         default: ;
      endcase
      exp_status.push_back(st);
      exp_found.push_back(fnd);
      exp_count.push_back(6'(val_q.size()));
   endfunction

   function void check_response(logic [2:0] st, logic [5:0] fnd, logic [5:0] cnt);
      logic [2:0] es;
      logic [5:0] ef, ec;
      if (exp_status.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected response status=%0d", st);
         return;
      end
      es = exp_status.pop_front();
      ef = exp_found.pop_front();
      ec = exp_count.pop_front();
      if (st !== es || fnd !== ef || cnt !== ec) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp st=%0d pos=%0d cnt=%0d, got st=%0d pos=%0d cnt=%0d",
                     es, ef, ec, st, fnd, cnt);
      end
   endfunction

   function int pending();
      return exp_status.size();
   endfunction
endclass

module linked_list_manager_tb;
   // codes outside the command set
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [llm_pkg::CMD_W-1:0] req_cmd = '0;
   logic [llm_pkg::POS_W-1:0] req_position = '0;
   logic signed [llm_pkg::VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [llm_pkg::STAT_W-1:0] rsp_status;
   logic [llm_pkg::POS_W-1:0] rsp_found_position;
   logic [llm_pkg::POS_W-1:0] rsp_node_count;

   list_scoreboard board = new();
   int cycles = 0;
   int stall_left = 0;
   bit stall_quiet = 0;
   // Small value pool so that searches and deletes by value hit often.
   logic [31:0] pool[8] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                            32'h1, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'h12345678};

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   linked_list_manager dut (.*);

   // Count cycles and end the run if it hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("linked_list_manager verification failed");
         $finish;
      end
   end

   // Check responses and drive random back pressure, mostly short, a few long.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_status, rsp_found_position, rsp_node_count);
         if (stall_quiet) begin
            stall_left <= 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < 3) begin
            stall_left <= $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   function int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Present one request, hold it until accepted, then drop valid for a random gap unless it is zero.
   task send_request(logic [2:0] cmd, logic [5:0] pos, logic [31:0] value);
      int gap;
      req_valid <= 1;
      req_cmd <= cmd;
      req_position <= pos;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      board.note_request(cmd, pos, value);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function logic [31:0] pick_value();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return pool[$urandom_range(0, 7)];
   endfunction

   initial begin
      int n;
      logic [2:0] cmd;
      logic [5:0] pos;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: commands on an empty list, bad positions, fill to full, unused codes.
      send_request(llm_pkg::CMD_DELETE_POS, 6'd1, 32'h0);
      send_request(llm_pkg::CMD_DELETE_VAL, 6'd0, 32'h0);
      send_request(llm_pkg::CMD_SEARCH, 6'd0, 32'h0);
      send_request(llm_pkg::CMD_REVERSE, 6'd0, 32'h0);
      send_request(llm_pkg::CMD_INSERT, 6'd0, 32'h1);
      send_request(llm_pkg::CMD_INSERT, 6'd2, 32'h1);
      send_request(llm_pkg::CMD_INSERT, 6'd1, 32'h80000000);
      send_request(llm_pkg::CMD_REVERSE, 6'd0, 32'h0);
      send_request(llm_pkg::CMD_INSERT, 6'd2, 32'h7fffffff);
      send_request(llm_pkg::CMD_INSERT, 6'd1, 32'hffffffff);
      send_request(llm_pkg::CMD_SEARCH, 6'd0, 32'h7fffffff);
      send_request(llm_pkg::CMD_DELETE_POS, 6'd3, 32'h0);
      send_request(llm_pkg::CMD_DELETE_POS, 6'd3, 32'h0);
      send_request(llm_pkg::CMD_DELETE_VAL, 6'd0, 32'h55555555);
      send_request(CMD_SPARE_A, 6'd63, 32'hffffffff);
      send_request(CMD_SPARE_B, 6'd0, 32'h0);
      for (int i = 0; i < 33; i++) send_request(llm_pkg::CMD_INSERT, 6'(i + 2), 32'(i));
      send_request(llm_pkg::CMD_INSERT, 6'd34, 32'h5);
      send_request(llm_pkg::CMD_INSERT, 6'd33, 32'h5);
      send_request(llm_pkg::CMD_DELETE_POS, 6'd33, 32'h0);
      send_request(llm_pkg::CMD_SEARCH, 6'd0, 32'd31);
      send_request(llm_pkg::CMD_REVERSE, 6'd0, 32'h0);
      send_request(llm_pkg::CMD_DELETE_POS, 6'd32, 32'h0);
      send_request(llm_pkg::CMD_CLEAR, 6'd0, 32'h0);
      // Random: inserts are the most common command, with a few clears.
      for (int i = 0; i < 1000; i++) begin
         stall_quiet = (i % 200) < 40;
         n = board.val_q.size();
         case ($urandom_range(0, 19))
            0,1,2,3,4,5,6: cmd = llm_pkg::CMD_INSERT;
            7,8,9: cmd = llm_pkg::CMD_DELETE_POS;
            10,11: cmd = llm_pkg::CMD_DELETE_VAL;
            12,13,14: cmd = llm_pkg::CMD_SEARCH;
            15,16: cmd = llm_pkg::CMD_REVERSE;
            17: cmd = ($urandom_range(0, 3) == 0) ? llm_pkg::CMD_CLEAR : llm_pkg::CMD_SEARCH;
            default: cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_B));
         endcase
         if ($urandom_range(0, 9) == 0) pos = 6'($urandom());
         else pos = 6'($urandom_range(1, n + 1));
         send_request(cmd, pos, pick_value());
      end
      req_valid <= 0;
      stall_quiet = 0;
      while (board.pending() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) $display("linked_list_manager verification clean");
      else $display("linked_list_manager verification failed");
      $finish;
   end
endmodule

FILE: linked_list_manager.f
+incdir+rtl
rtl/llm_pkg.sv
rtl/llm_node_ram.sv
rtl/linked_list_manager.sv
tb/linked_list_manager_tb.sv
